### rtl/core/tcpct_pkg.sv
// Package with the connection table types, codes and the state transition function.
package tcpct_pkg;

  localparam int unsigned KeyW = 96;

  localparam logic [1:0] TCP_CLOSED       = 2'd0;
  localparam logic [1:0] TCP_SYN_SEEN     = 2'd1;
  localparam logic [1:0] TCP_ESTABLISHED  = 2'd2;
  localparam logic [1:0] TCP_FIN_WAIT     = 2'd3;

  localparam logic [1:0] OUT_IGNORED = 2'd0;
  localparam logic [1:0] OUT_UPDATED = 2'd1;
  localparam logic [1:0] OUT_CREATED = 2'd2;
  localparam logic [1:0] OUT_FULL    = 2'd3;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [1:0]      conn_state;
    logic [31:0]     seq;
    logic [31:0]     ackn;
  } entry_t;

  function automatic logic [1:0] next_conn_state(input logic [1:0] cur, input logic syn,
                                                 input logic ack, input logic fin,
                                                 input logic rst);
    logic [1:0] ns;
    ns = cur;
    if (rst) begin
      ns = TCP_CLOSED;
    end else begin
      case (cur)
        TCP_CLOSED:       ns = (syn && !ack) ? TCP_SYN_SEEN : TCP_CLOSED;
        TCP_SYN_SEEN:     ns = ack ? TCP_ESTABLISHED : TCP_SYN_SEEN;
        TCP_ESTABLISHED:  ns = fin ? TCP_FIN_WAIT : TCP_ESTABLISHED;
        default:          ns = ack ? TCP_CLOSED : TCP_FIN_WAIT;
      endcase
    end
    return ns;
  endfunction

endpackage

### rtl/core/tcpct_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tcpct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/tcp_connection_tracker.sv
// Top level of the TCP connection tracker: table scan, state update and result register.
//
//  Channel  | Dir | tdata fields (low bit first)                         | tuser
//  s_axis   | in  | src addr 32, dst addr 32, src port 16, dst port 16,  | syn, ack, fin, rst
//           |     | seq 32, ack number 32 (160 bits)                     |
//  m_axis   | out | outcome 2, new state 2, prev seq 32, prev ack 32,    | none
//           |     | active count 7, zero pad 5 (80 bits)                 |
//
// Each request passes through three steps: capture of the header, a scan of the table RAM
// (one entry read per cycle through its single read port, with registered read data), and
// the write back of the entry together with the load of the result.
// After reset the block sweeps the table once, clearing every entry's valid bit;
// no request is accepted during that sweep.
// The result register holds a finished result while the next request is taken and
// scanned; the write back of that next request waits until the held result is taken.
module tcp_connection_tracker
  import tcpct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src addr [31:0], dst addr [63:32], src port [79:64], dst port [95:80],
  // seq [127:96], ack number [159:128]
  input  logic [159:0] s_axis_tdata,
  // syn [0], ack [1], fin [2], rst [3]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // outcome [1:0], new state [3:2], prev seq [35:4], prev ack [67:36], count [74:68]
  output logic [79:0]  m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EntW  = $bits(entry_t);
  localparam logic [CntW-1:0] Entries = CntW'(TABLE_ENTRIES);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] FSM_CLEAR = 2'd0;
  localparam logic [1:0] FSM_IDLE  = 2'd1;
  localparam logic [1:0] FSM_SCAN  = 2'd2;
  localparam logic [1:0] FSM_UPD   = 2'd3;

  logic [1:0]       fsm_q, fsm_d;
  logic [CntW-1:0]  cnt_q, cnt_d;          // sweep and read address counter
  logic             cmp_vld_q, cmp_vld_d;  // read data of cmp_idx_q arrives this cycle
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [AddrW-1:0] hit_idx_q, hit_idx_d;
  logic [1:0]       hit_st_q, hit_st_d;
  logic [31:0]      hit_seq_q, hit_seq_d;
  logic [31:0]      hit_ack_q, hit_ack_d;
  logic             free_q, free_d;
  logic [AddrW-1:0] free_idx_q, free_idx_d;
  logic [CntW-1:0]  conn_q, conn_d;
  logic [159:0]     hdr_q, hdr_d;
  logic [3:0]       flg_q, flg_d;
  logic             out_vld_q, out_vld_d;
  logic [74:0]      out_q, out_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic [KeyW-1:0]  key;
  logic [31:0]      pkt_seq, pkt_ack;
  logic             f_syn, f_ack, f_fin, f_rst;
  logic             upd_go;
  logic [1:0]       upd_outcome, upd_state;
  logic [31:0]      upd_pseq, upd_pack;
  logic [CntW+6:0]  conn_ext;

  assign key     = hdr_q[95:0];
  assign pkt_seq = hdr_q[127:96];
  assign pkt_ack = hdr_q[159:128];
  assign f_syn   = flg_q[0];
  assign f_ack   = flg_q[1];
  assign f_fin   = flg_q[2];
  assign f_rst   = flg_q[3];

  tcpct_ram #(
    .WIDTH(EntW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (fsm_q == FSM_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q};

  // The write back may only load the result register once it is free.
  assign upd_go = (fsm_q == FSM_UPD) && (!out_vld_q || m_axis_tready);

  always_comb begin
    fsm_d      = fsm_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_st_d   = hit_st_q;
    hit_seq_d  = hit_seq_q;
    hit_ack_d  = hit_ack_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    conn_d     = conn_q;
    hdr_d      = hdr_q;
    flg_d      = flg_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AddrW-1:0];
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cnt_q[AddrW-1:0];
    upd_outcome = OUT_IGNORED;
    upd_state   = TCP_CLOSED;
    upd_pseq    = '0;
    upd_pack    = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (fsm_q)
      FSM_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q[AddrW-1:0] == LastIdx) begin
          fsm_d = FSM_IDLE;
          cnt_d = '0;
        end
      end
      FSM_IDLE: begin
        if (s_axis_tvalid) begin
          hdr_d  = s_axis_tdata;
          flg_d  = s_axis_tuser;
          hit_d  = 1'b0;
          free_d = 1'b0;
          cnt_d  = '0;
          fsm_d  = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (cnt_q < Entries) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[AddrW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (ram_rdata.valid) begin
            if (!hit_q && ram_rdata.key == key) begin
              hit_d     = 1'b1;
              hit_idx_d = cmp_idx_q;
              hit_st_d  = ram_rdata.conn_state;
              hit_seq_d = ram_rdata.seq;
              hit_ack_d = ram_rdata.ackn;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == LastIdx) begin
            fsm_d = FSM_UPD;
          end
        end
      end
      default: begin
        if (hit_q) begin
          upd_outcome = OUT_UPDATED;
          upd_pseq    = hit_seq_q;
          upd_pack    = hit_ack_q;
          upd_state   = next_conn_state(hit_st_q, f_syn, f_ack, f_fin, f_rst);
        end else if (f_syn && !f_ack) begin
          if (!free_q) begin
            upd_outcome = OUT_FULL;
          end else begin
            upd_outcome = OUT_CREATED;
            upd_pseq    = pkt_seq;
            upd_pack    = pkt_ack;
            upd_state   = next_conn_state(TCP_CLOSED, f_syn, f_ack, f_fin, f_rst);
          end
        end
        ram_wdata.valid      = (upd_state != TCP_CLOSED);
        ram_wdata.key        = key;
        ram_wdata.conn_state = upd_state;
        ram_wdata.seq        = pkt_seq;
        ram_wdata.ackn       = pkt_ack;
        ram_waddr            = hit_q ? hit_idx_q : free_idx_q;
        if (upd_go) begin
          ram_we = (upd_outcome == OUT_UPDATED) ||
                   ((upd_outcome == OUT_CREATED) && (upd_state != TCP_CLOSED));
          if (upd_outcome == OUT_UPDATED && upd_state == TCP_CLOSED && conn_q != '0) begin
            conn_d = conn_q - 1'b1;
          end else if (upd_outcome == OUT_CREATED && upd_state != TCP_CLOSED) begin
            conn_d = conn_q + 1'b1;
          end
          out_vld_d = 1'b1;
          fsm_d     = FSM_IDLE;
        end
      end
    endcase

    conn_ext = {7'b0, conn_d};
    if (upd_go) begin
      out_d = {conn_ext[6:0], upd_pack, upd_pseq, upd_state, upd_outcome};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= FSM_CLEAR;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      conn_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      fsm_q     <= fsm_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      conn_q    <= conn_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_st_q   <= hit_st_d;
    hit_seq_q  <= hit_seq_d;
    hit_ack_q  <= hit_ack_d;
    free_idx_q <= free_idx_d;
    hdr_q      <= hdr_d;
    flg_q      <= flg_d;
    out_q      <= out_d;
  end

  // The count of tracked connections never exceeds the table size.
  a_conn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_q <= Entries)
    else $error("connection count above table size");

  // A dropped request is only reported when every entry is in use.
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go && upd_outcome == OUT_FULL |-> conn_q == Entries)
    else $error("table full reported with free entries");

  // The table is never written while a request is being scanned.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == FSM_SCAN |-> !ram_we)
    else $error("table write during scan");

  // A result is only loaded by the write back step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q ##1 out_vld_q |-> $past(fsm_q) == FSM_UPD)
    else $error("result appeared outside the write back step");

endmodule

### test/testbench.sv
// Testbench for the TCP connection tracker: random and directed headers checked against a table model.
`timescale 1ns / 100ps

module testbench;
  import tcpct_pkg::*;

  localparam int unsigned Entries = 64;
  localparam int unsigned LimitCycles = 900000;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  conn_state;
    logic [31:0] prev_seq;
    logic [31:0] prev_ackn;
    logic [6:0]  count;
  } verdict_t;

  typedef struct {
    logic [95:0] key;
    logic [3:0]  flags;  // syn [0], ack [1], fin [2], rst [3]
    logic [31:0] seq;
    logic [31:0] ackn;
  } header_t;

  int unsigned errors;

  task automatic report(input string what);
    $display("MISMATCH %s", what);
    errors++;
  endtask

  // Table model and queue of expected verdicts.
  class conn_scoreboard;
    bit          used[Entries];
    logic [95:0] keys[Entries];
    logic [1:0]  states[Entries];
    logic [31:0] seqs[Entries];
    logic [31:0] ackns[Entries];
    int unsigned active;
    verdict_t    pending[$];
    int unsigned creates, fulls, updates, ignores;

    function logic [1:0] advance(input logic [1:0] cur, input logic [3:0] f);
      if (f[3]) return TCP_CLOSED;
      case (cur)
        TCP_CLOSED:       return (f[0] && !f[1]) ? TCP_SYN_SEEN : TCP_CLOSED;
        TCP_SYN_SEEN:     return f[1] ? TCP_ESTABLISHED : TCP_SYN_SEEN;
        TCP_ESTABLISHED:  return f[2] ? TCP_FIN_WAIT : TCP_ESTABLISHED;
        default:          return f[1] ? TCP_CLOSED : TCP_FIN_WAIT;
      endcase
    endfunction

    function void note_header(input header_t h);
      int hit, spare;
      verdict_t v;
      hit = -1;
      spare = -1;
      v = '0;
      for (int i = 0; i < Entries; i++) begin
        if (used[i]) begin
          if (hit < 0 && keys[i] == h.key) hit = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      v.conn_state = TCP_CLOSED;
      if (hit < 0) begin
        if (h.flags[0] && !h.flags[1]) begin
          if (spare < 0) begin
            v.outcome = OUT_FULL;
            fulls++;
          end else begin
            v.outcome = OUT_CREATED;
            v.prev_seq = h.seq;
            v.prev_ackn = h.ackn;
            v.conn_state = advance(TCP_CLOSED, h.flags);
            creates++;
            if (v.conn_state != TCP_CLOSED) begin
              used[spare] = 1;
              keys[spare] = h.key;
              states[spare] = v.conn_state;
              seqs[spare] = h.seq;
              ackns[spare] = h.ackn;
              active++;
            end
          end
        end else begin
          v.outcome = OUT_IGNORED;
          ignores++;
        end
      end else begin
        v.outcome = OUT_UPDATED;
        v.prev_seq = seqs[hit];
        v.prev_ackn = ackns[hit];
        v.conn_state = advance(states[hit], h.flags);
        states[hit] = v.conn_state;
        seqs[hit] = h.seq;
        ackns[hit] = h.ackn;
        updates++;
        if (v.conn_state == TCP_CLOSED) begin
          used[hit] = 0;
          if (active > 0) active--;
        end
      end
      v.count = active[6:0];
      pending.push_back(v);
    endfunction

    task check_result(input logic [79:0] d);
      verdict_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      w = pending.pop_front();
      if (d[1:0] !== w.outcome) report($sformatf("outcome %0d want %0d", d[1:0], w.outcome));
      if (d[3:2] !== w.conn_state)
        report($sformatf("state %0d want %0d", d[3:2], w.conn_state));
      if (d[35:4] !== w.prev_seq) report($sformatf("prev seq %h want %h", d[35:4], w.prev_seq));
      if (d[67:36] !== w.prev_ackn)
        report($sformatf("prev ack %h want %h", d[67:36], w.prev_ackn));
      if (d[74:68] !== w.count) report($sformatf("count %0d want %0d", d[74:68], w.count));
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [79:0]  m_axis_tdata;

  conn_scoreboard board = new();
  int unsigned cycles;
  bit          calm;  // no idling in the closing part
  logic [95:0] flows[$];

  tcp_connection_tracker #(.TABLE_ENTRIES(Entries)) uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Receiver: random stall bursts, checks every taken result.
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (!calm && m_axis_tready && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 0;
        gap = $urandom_range(1, 12);
        repeat (gap - 1) @(posedge clk_i);
        // the output cannot be valid-and-taken while ready is low
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_header(input header_t h);
    s_axis_tdata <= {h.ackn, h.seq, h.key};
    s_axis_tuser <= h.flags;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_header(h);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [95:0] random_key();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  function automatic header_t make_header(input logic [95:0] k, input logic [3:0] f);
    header_t h;
    h.key = k;
    h.flags = f;
    h.seq = $urandom();
    h.ackn = $urandom();
    return h;
  endfunction

  // A well-formed connection lifetime, sometimes cut short by a reset.
  task automatic send_lifetime(input logic [95:0] k);
    send_header(make_header(k, 4'b0001));
    if ($urandom_range(0, 5) == 0) begin
      send_header(make_header(k, 4'b1000));
      return;
    end
    send_header(make_header(k, 4'b0010));
    repeat ($urandom_range(0, 3)) send_header(make_header(k, 4'b0010));
    send_header(make_header(k, 4'b0110));
    send_header(make_header(k, 4'b0010));
  endtask

  initial begin
    logic [95:0] k;
    header_t h;
    int choice;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: extreme keys and numbers, every flag path, create with reset.
    h.key = '1; h.flags = 4'b0001; h.seq = '1; h.ackn = '1;
    send_header(h);
    h.flags = 4'b0011; h.seq = '0; h.ackn = '0;
    send_header(h);
    h.flags = 4'b0100; send_header(h);
    h.flags = 4'b0011; send_header(h);
    h.key = '0; h.flags = 4'b0010; send_header(h);  // untracked ack is ignored
    h.flags = 4'b1001; send_header(h);  // create with reset closes at once
    h.flags = 4'b0001; send_header(h);
    h.flags = 4'b0001; send_header(h);  // repeated syn stays
    h.flags = 4'b1111; send_header(h);  // reset from the half-open state
    h.flags = 4'b0111; send_header(h);  // ignored, syn with ack
    // Fill the table, then overflow with and without reset.
    for (int i = 0; i < Entries; i++) begin
      k = random_key();
      flows.push_back(k);
      send_header(make_header(k, 4'b0001));
    end
    send_header(make_header(random_key(), 4'b0001));
    send_header(make_header(random_key(), 4'b1001));
    send_header(make_header(random_key(), 4'b0101));
    foreach (flows[i]) send_header(make_header(flows[i], 4'b1000));
    flows.delete();

    // Random: mostly lifetimes with noise headers on live and fresh keys.
    for (int n = 0; n < 450; n++) begin
      if (n > 375) calm = 1;
      choice = $urandom_range(0, 9);
      if (choice < 4) begin
        k = random_key();
        if (flows.size() < 80) flows.push_back(k);
        send_lifetime(k);
      end else if (choice < 8 && flows.size() > 0) begin
        send_header(make_header(flows[$urandom_range(0, flows.size() - 1)],
                                4'($urandom())));
      end else begin
        send_header(make_header(random_key(), 4'($urandom())));
      end
    end

    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Entries + 10) @(posedge clk_i);
    $display("Covered %0d creations, %0d updates, %0d ignored, %0d full drops.",
             board.creates, board.updates, board.ignores, board.fulls);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
